/* rtl/wcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_pkg
// Widths, register defaults, grade codes and the sRGB linearization table
// of the contrast ratio block.
// ----------------------------------------------------------------------------
package wcr_pkg;

  localparam int LUM_FRAC   = 16;
  localparam int RATIO_FRAC = 8;

  localparam int CH_W     = 8;
  localparam int LIN_FRAC = 31;
  localparam int LIN_W    = LIN_FRAC + 1;
  localparam int W_W      = LUM_FRAC;
  localparam int PROD_W   = LIN_W + W_W;
  localparam int LUM_W    = LUM_FRAC + 1;
  localparam int NUM_W    = LUM_FRAC + 5;
  localparam int RATIO_W  = RATIO_FRAC + 5;
  localparam int DIV_N_W  = NUM_W + RATIO_FRAC;
  localparam int TAB_N    = 256;

  localparam logic [W_W-1:0] W_RED   = W_W'(((64'd2126 << LUM_FRAC) + 64'd5000) / 64'd10000);
  localparam logic [W_W-1:0] W_GREEN = W_W'(((64'd7152 << LUM_FRAC) + 64'd5000) / 64'd10000);
  localparam logic [W_W-1:0] W_BLUE  = W_W'(((64'd722 << LUM_FRAC) + 64'd5000) / 64'd10000);
  localparam logic [NUM_W-1:0] LUM_ONE = NUM_W'(64'd1 << LUM_FRAC);

  localparam logic [RATIO_W-1:0] MIN_RESET = RATIO_W'(1152);
  localparam logic [RATIO_W-1:0] ENH_RESET = RATIO_W'(1792);

  localparam int CFG_ADDR_W = 3;
  typedef enum logic {
    REG_MINIMUM  = 1'b0,
    REG_ENHANCED = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    GRADE_NONE     = 2'd0,
    GRADE_MINIMUM  = 2'd1,
    GRADE_ENHANCED = 2'd2
  } grade_e;

  typedef struct packed {
    logic [CH_W-1:0] second_blue;
    logic [CH_W-1:0] second_green;
    logic [CH_W-1:0] second_red;
    logic [CH_W-1:0] first_blue;
    logic [CH_W-1:0] first_green;
    logic [CH_W-1:0] first_red;
  } pair_t;

  typedef struct packed {
    logic [NUM_W-1:0]   rem;
    logic [NUM_W-1:0]   den;
    logic [RATIO_W-1:0] low;
    logic [RATIO_W-1:0] quot;
  } div_t;

  typedef struct packed {
    logic [LUM_W-1:0] first_lum;
    logic [LUM_W-1:0] second_lum;
  } pay_t;

  typedef logic [LIN_W-1:0] lin_tab_t [TAB_N];

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> LIN_FRAC;
  endfunction

  function automatic logic [63:0] fifth_power(input logic [63:0] r);
    logic [63:0] p;
    p = qmul(r, r);
    p = qmul(p, r);
    p = qmul(p, r);
    return qmul(p, r);
  endfunction

  function automatic logic [LIN_W-1:0] lin_entry(input int unsigned v);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] c;
    if (v <= 10) begin
      x = (64'(v) * 64'd10) << LIN_FRAC;
      return LIN_W'(x / 64'd32946);
    end
    x = (64'd1000 * 64'(v) + 64'd14025) << LIN_FRAC;
    t = x / 64'd269025;
    u = qmul(t, t);
    r = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c <= (64'd1 << LIN_FRAC) && fifth_power(c) <= u) begin
        r = c;
      end
    end
    return LIN_W'(qmul(u, r));
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t tab;
    for (int i = 0; i < TAB_N; i++) begin
      tab[i] = lin_entry(i);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

/* rtl/wcr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_front
// Linearize, weight and sum both colors, then set up the ratio division.
// ----------------------------------------------------------------------------
module wcr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  wcr_pkg::pair_t        pair_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output wcr_pkg::div_t         div_o,
  output wcr_pkg::pay_t         pay_o
);
  import wcr_pkg::*;

  logic [3:0] v_q;
  logic [3:0] ld;

  logic [LIN_W-1:0]  lin_q [6];
  logic [PROD_W-1:0] prod_q [6];
  logic [LUM_W-1:0]  lum1_q, lum2_q;
  div_t              div_q;
  pay_t              pay_q;

  logic [PROD_W-1:0]  sum1, sum2;
  logic [LUM_W-1:0]   hi, lo;
  logic [NUM_W-1:0]   num, den;
  logic [DIV_N_W-1:0] n_full;
  logic [W_W-1:0]     wt [6];

  assign wt[0] = W_RED;
  assign wt[1] = W_GREEN;
  assign wt[2] = W_BLUE;
  assign wt[3] = W_RED;
  assign wt[4] = W_GREEN;
  assign wt[5] = W_BLUE;

  assign ld[3]   = ~v_q[3] | ready_i;
  assign ld[2]   = ~v_q[2] | ld[3];
  assign ld[1]   = ~v_q[1] | ld[2];
  assign ld[0]   = ~v_q[0] | ld[1];
  assign ready_o = ld[0];
  assign valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      if (ld[1]) v_q[1] <= v_q[0];
      if (ld[2]) v_q[2] <= v_q[1];
      if (ld[3]) v_q[3] <= v_q[2];
    end
  end

  assign sum1 = prod_q[0] + prod_q[1] + prod_q[2];
  assign sum2 = prod_q[3] + prod_q[4] + prod_q[5];

  assign hi     = (lum1_q > lum2_q) ? lum1_q : lum2_q;
  assign lo     = (lum1_q > lum2_q) ? lum2_q : lum1_q;
  assign num    = (NUM_W'(hi) << 4) + (NUM_W'(hi) << 2) + LUM_ONE;
  assign den    = (NUM_W'(lo) << 4) + (NUM_W'(lo) << 2) + LUM_ONE;
  assign n_full = {num, RATIO_FRAC'(0)};

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      lin_q[0] <= LIN_TABLE[pair_i.first_red];
      lin_q[1] <= LIN_TABLE[pair_i.first_green];
      lin_q[2] <= LIN_TABLE[pair_i.first_blue];
      lin_q[3] <= LIN_TABLE[pair_i.second_red];
      lin_q[4] <= LIN_TABLE[pair_i.second_green];
      lin_q[5] <= LIN_TABLE[pair_i.second_blue];
    end
    if (ld[1]) begin
      for (int i = 0; i < 6; i++) begin
        prod_q[i] <= PROD_W'(lin_q[i]) * PROD_W'(wt[i]);
      end
    end
    if (ld[2]) begin
      lum1_q <= sum1[PROD_W-1:LIN_FRAC];
      lum2_q <= sum2[PROD_W-1:LIN_FRAC];
    end
    if (ld[3]) begin
      div_q.rem        <= NUM_W'(n_full >> RATIO_W);
      div_q.den        <= den;
      div_q.low        <= n_full[RATIO_W-1:0];
      div_q.quot       <= '0;
      pay_q.first_lum  <= lum1_q;
      pay_q.second_lum <= lum2_q;
    end
  end

  assign div_o = div_q;
  assign pay_o = pay_q;

endmodule

/* rtl/wcr_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcr_div_cell
// One restoring division step: bring down a bit, subtract, shift in a
// quotient bit, and hand the request on to the next cell.
// ----------------------------------------------------------------------------
module wcr_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wcr_pkg::div_t div_i,
  input  wcr_pkg::pay_t pay_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wcr_pkg::div_t div_o,
  output wcr_pkg::pay_t pay_o
);
  import wcr_pkg::*;

  logic         v_q;
  div_t         div_q;
  pay_t         pay_q;
  logic         ld;
  logic [NUM_W:0] trial;
  logic         ge;
  logic [NUM_W:0] diff;

  assign ld      = ~v_q | ready_i;
  assign ready_o = ld;
  assign valid_o = v_q;

  assign trial = {div_i.rem, div_i.low[RATIO_W-1]};
  assign ge    = trial >= {1'b0, div_i.den};
  assign diff  = trial - {1'b0, div_i.den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      div_q.rem  <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      div_q.den  <= div_i.den;
      div_q.low  <= {div_i.low[RATIO_W-2:0], 1'b0};
      div_q.quot <= {div_i.quot[RATIO_W-2:0], ge};
      pay_q      <= pay_i;
    end
  end

  assign div_o = div_q;
  assign pay_o = pay_q;

endmodule

/* rtl/wcag_contrast_ratio.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcag_contrast_ratio
// WCAG relative luminance and contrast ratio of a pair of sRGB colors.
// ----------------------------------------------------------------------------
// Takes one color pair per clock and returns both Q16 luminances, the ratio
// (lighter + 0.05) / (darker + 0.05) with 8 fraction bits rounded down, and a
// grade against the minimum and enhanced thresholds. Work passes through
// registered table lookup, weighting, summing and setup stages, a chain of 13
// division cells that each resolve one ratio bit, and one output register.
// The cells pass work on every cycle, so a new pair enters each clock while
// the output side keeps up; a stall holds only the stages that are full.
// ----------------------------------------------------------------------------
module wcag_contrast_ratio (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [7:0] first_red, [15:8] first_green, [23:16] first_blue,
  // [31:24] second_red, [39:32] second_green, [47:40] second_blue
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] contrast_ratio, [29:13] first_luminance, [46:30] second_luminance,
  // [48:47] grade, [55:49] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [wcr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wcr_pkg::*;

  logic [RATIO_W-1:0] min_q, enh_q;
  reg_idx_e           cfg_idx;

  logic valid [RATIO_W+1];
  logic ready [RATIO_W+1];
  div_t div   [RATIO_W+1];
  pay_t pay   [RATIO_W+1];

  logic               out_v_q;
  logic               out_ld;
  logic [RATIO_W-1:0] ratio_q;
  pay_t               pay_q;
  grade_e             grade_q;
  grade_e             grade_d;
  logic [RATIO_W-1:0] ratio;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
      enh_q <= ENH_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_MINIMUM:  min_q <= pwdata[RATIO_W-1:0];
        REG_ENHANCED: enh_q <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MINIMUM:  prdata = 32'(min_q);
      REG_ENHANCED: prdata = 32'(enh_q);
      default:      prdata = '0;
    endcase
  end

  wcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pair_i  (pair_t'(s_axis_tdata)),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .div_o   (div[0]),
    .pay_o   (pay[0])
  );

  for (genvar k = 0; k < RATIO_W; k++) begin : g_cell
    wcr_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .div_i   (div[k]),
      .pay_i   (pay[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .div_o   (div[k+1]),
      .pay_o   (pay[k+1])
    );
  end

  assign ratio           = div[RATIO_W].quot;
  assign out_ld          = ~out_v_q | m_axis_tready;
  assign ready[RATIO_W]  = out_ld;

  always_comb begin
    if (ratio >= enh_q) begin
      grade_d = GRADE_ENHANCED;
    end else if (ratio >= min_q) begin
      grade_d = GRADE_MINIMUM;
    end else begin
      grade_d = GRADE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ld) begin
      out_v_q <= valid[RATIO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      ratio_q <= ratio;
      pay_q   <= pay[RATIO_W];
      grade_q <= grade_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, grade_q, pay_q.second_lum, pay_q.first_lum, ratio_q};

`ifndef SYNTHESIS
  a_ratio_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[12:0] >= 13'd256))
    else $error("ratio below 1.0");

  a_equal_lum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[29:13] == m_axis_tdata[46:30]))
      |-> (m_axis_tdata[12:0] == 13'd256))
    else $error("equal luminances without unit ratio");

  a_lum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[29:13] <= 17'd65536 &&
                       m_axis_tdata[46:30] <= 17'd65536))
    else $error("luminance above 1.0");
`endif

endmodule

/* tb/wcag_contrast_ratio_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcag_contrast_ratio_tb
// Self-checking bench for the WCAG contrast ratio block.
// ----------------------------------------------------------------------------
// Color pairs stream in while a scoreboard works out both luminances, the
// ratio and the grade from its own sRGB table and threshold copies, and
// checks every result in order. Runs cover idle and stall mixes on both
// sides, a long output hold, a full drain, and several threshold settings.
// ----------------------------------------------------------------------------

class contrast_scoreboard;
  typedef struct {
    logic [12:0]     ratio;
    logic [16:0]     first_lum;
    logic [16:0]     second_lum;
    wcr_pkg::grade_e grade;
  } contrast_t;

  logic [63:0] srgb_linear [256];
  logic [12:0] min_thresh;
  logic [12:0] enh_thresh;
  contrast_t   awaited [$];
  int          errors;

  function logic [63:0] fxmul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 31;
  endfunction

  function logic [63:0] pow5(logic [63:0] r);
    logic [63:0] p;
    p = fxmul(r, r);
    p = fxmul(p, r);
    p = fxmul(p, r);
    return fxmul(p, r);
  endfunction

  function new();
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] c;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        srgb_linear[v] = ((64'(v) * 64'd10) << 31) / 64'd32946;
      end else begin
        t = ((64'd1000 * 64'(v) + 64'd14025) << 31) / 64'd269025;
        u = fxmul(t, t);
        r = 0;
        for (int b = 31; b >= 0; b--) begin
          c = r | (64'd1 << b);
          if (c <= (64'd1 << 31) && pow5(c) <= u) r = c;
        end
        srgb_linear[v] = fxmul(u, r);
      end
    end
    min_thresh = 13'd1152;
    enh_thresh = 13'd1792;
    errors     = 0;
  endfunction

  function void set_threshold(wcr_pkg::reg_idx_e idx, logic [31:0] value);
    if (idx == wcr_pkg::REG_MINIMUM) min_thresh = value[12:0];
    else enh_thresh = value[12:0];
  endfunction

  function logic [63:0] luminance(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [63:0] acc;
    acc = 64'd13933 * srgb_linear[r] + 64'd46871 * srgb_linear[g]
        + 64'd4732 * srgb_linear[b];
    return acc >> 31;
  endfunction

  function void note_pair(wcr_pkg::pair_t p);
    contrast_t   e;
    logic [63:0] l1;
    logic [63:0] l2;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] q;
    l1 = luminance(p.first_red, p.first_green, p.first_blue);
    l2 = luminance(p.second_red, p.second_green, p.second_blue);
    hi = (l1 > l2) ? l1 : l2;
    lo = (l1 > l2) ? l2 : l1;
    q  = ((64'd20 * hi + 64'd65536) << 8) / (64'd20 * lo + 64'd65536);
    e.ratio      = q[12:0];
    e.first_lum  = l1[16:0];
    e.second_lum = l2[16:0];
    if (q >= enh_thresh) e.grade = wcr_pkg::GRADE_ENHANCED;
    else if (q >= min_thresh) e.grade = wcr_pkg::GRADE_MINIMUM;
    else e.grade = wcr_pkg::GRADE_NONE;
    awaited.push_back(e);
  endfunction

  function void check_result(logic [55:0] d);
    contrast_t e;
    if (awaited.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (d[12:0] !== e.ratio) begin
      $error("contrast_ratio exp %0d got %0d", e.ratio, d[12:0]);
      errors++;
    end
    if (d[29:13] !== e.first_lum) begin
      $error("first_luminance exp %0d got %0d", e.first_lum, d[29:13]);
      errors++;
    end
    if (d[46:30] !== e.second_lum) begin
      $error("second_luminance exp %0d got %0d", e.second_lum, d[46:30]);
      errors++;
    end
    if (d[48:47] !== e.grade) begin
      $error("grade exp %0d got %0d", e.grade, d[48:47]);
      errors++;
    end
    if (d[55:49] !== 7'd0) begin
      $error("pad exp 0 got %0h", d[55:49]);
      errors++;
    end
  endfunction
endclass

module wcag_contrast_ratio_tb;
  import wcr_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  contrast_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  wcag_contrast_ratio dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_pair(pair_t p);
    logic ok;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tdata  <= p;
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    sb.note_pair(p);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_threshold(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_threshold(idx, value);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(3))
      0: return 8'(($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 255 : 10));
      1: return 8'($urandom_range(9, 12));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pair_t pick_pair();
    pair_t p;
    p.first_red    = pick_channel();
    p.first_green  = pick_channel();
    p.first_blue   = pick_channel();
    p.second_red   = pick_channel();
    p.second_green = pick_channel();
    p.second_blue  = pick_channel();
    if ($urandom_range(7) == 0) begin
      p.second_red   = p.first_red;
      p.second_green = p.first_green;
      p.second_blue  = p.first_blue;
    end
    return p;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_pair(pick_pair());
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tvalid  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rx_hold_cycles = 0;
    tx_idle_pct    = 32;
    rx_idle_pct    = 85;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // white on black, black on white, equal, transfer knee, primaries, grays
    send_pair(48'h000000_FFFFFF);
    send_pair(48'hFFFFFF_000000);
    send_pair(48'h000000_000000);
    send_pair(48'hFFFFFF_FFFFFF);
    send_pair(48'h0A0A0A_0B0B0B);
    send_pair(48'h0B0B0B_0A0A0A);
    send_pair(48'h000000_0A0A0A);
    send_pair(48'h0000FF_00FF00);
    send_pair(48'hFF0000_0000FF);
    send_pair(48'h00FF00_FF0000);
    send_pair(48'h767676_FFFFFF);
    send_pair(48'h595959_FFFFFF);
    send_pair(48'h808080_808080);
    send_pair(48'h010203_FEFDFC);
    send_pair(48'h555555_AAAAAA);
    send_pair(48'h000001_000000);
    send_random(420);
    drain();

    write_threshold(REG_MINIMUM, 32'd0);
    write_threshold(REG_ENHANCED, 32'd8191);
    tx_idle_pct = 85;
    rx_idle_pct = 32;
    send_pair(48'h000000_FFFFFF);
    send_random(420);
    drain();

    // inverted order, upper bits set in the written value
    write_threshold(REG_MINIMUM, 32'hFFFF_E000 | 32'd5375);
    write_threshold(REG_ENHANCED, 32'hA5A5_0000 | 32'd256);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(200);
    rx_hold_cycles = 300;
    send_random(100);
    drain();
    send_random(120);
    drain();

    write_threshold(REG_MINIMUM, 32'd256);
    write_threshold(REG_ENHANCED, 32'd5375);
    send_pair(48'h000000_FFFFFF);
    send_pair(48'h000000_000000);
    send_random(40);
    drain();

    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
